// ----- sv/hkm_pkg.sv -----
// hkm_pkg: types, codes and the key binding rom of the held-key note mapper
// no dependencies; imported by hkm_ctrl, hkm_dp, held_key_note_mapper and tb
package hkm_pkg;

  localparam int ROM_SIZE = 31;
  localparam int ROM_IW   = 5;

  localparam logic [1:0] MODE_KEY     = 2'd0;
  localparam logic [1:0] MODE_CANCEL  = 2'd1;
  localparam logic [1:0] MODE_REL_ALL = 2'd2;

  localparam logic [1:0] KIND_NONE    = 2'd0;
  localparam logic [1:0] KIND_NOTE    = 2'd1;
  localparam logic [1:0] KIND_SUSTAIN = 2'd2;

  localparam logic REG_GESTURE_PREFIX = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_KEY,
    ST_SCAN
  } state_t;

  typedef struct packed {
    logic [15:0] usage;
    logic [1:0]  kind;
    logic [6:0]  note;
  } binding_t;

  typedef struct packed {
    logic load;
    logic key_emit;
    logic cancel;
    logic scan_emit;
    logic scan_next;
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       rem_zero;
    logic       scan_held;
    logic       scan_end;
    logic       out_free;
  } status_t;

  function automatic binding_t rom_entry(input logic [ROM_IW-1:0] idx);
    binding_t b;
    case (idx)
      5'd0:    b = '{16'h001d, KIND_NOTE, 7'd60};
      5'd1:    b = '{16'h0016, KIND_NOTE, 7'd61};
      5'd2:    b = '{16'h001b, KIND_NOTE, 7'd62};
      5'd3:    b = '{16'h0007, KIND_NOTE, 7'd63};
      5'd4:    b = '{16'h0006, KIND_NOTE, 7'd64};
      5'd5:    b = '{16'h0019, KIND_NOTE, 7'd65};
      5'd6:    b = '{16'h000a, KIND_NOTE, 7'd66};
      5'd7:    b = '{16'h0005, KIND_NOTE, 7'd67};
      5'd8:    b = '{16'h000b, KIND_NOTE, 7'd68};
      5'd9:    b = '{16'h0011, KIND_NOTE, 7'd69};
      5'd10:   b = '{16'h000d, KIND_NOTE, 7'd70};
      5'd11:   b = '{16'h0010, KIND_NOTE, 7'd71};
      5'd12:   b = '{16'h0014, KIND_NOTE, 7'd72};
      5'd13:   b = '{16'h001f, KIND_NOTE, 7'd73};
      5'd14:   b = '{16'h001a, KIND_NOTE, 7'd74};
      5'd15:   b = '{16'h0020, KIND_NOTE, 7'd75};
      5'd16:   b = '{16'h0008, KIND_NOTE, 7'd76};
      5'd17:   b = '{16'h0015, KIND_NOTE, 7'd77};
      5'd18:   b = '{16'h0022, KIND_NOTE, 7'd78};
      5'd19:   b = '{16'h0017, KIND_NOTE, 7'd79};
      5'd20:   b = '{16'h0023, KIND_NOTE, 7'd80};
      5'd21:   b = '{16'h001c, KIND_NOTE, 7'd81};
      5'd22:   b = '{16'h0024, KIND_NOTE, 7'd82};
      5'd23:   b = '{16'h0018, KIND_NOTE, 7'd83};
      5'd24:   b = '{16'h000c, KIND_NOTE, 7'd84};
      5'd25:   b = '{16'h0026, KIND_NOTE, 7'd85};
      5'd26:   b = '{16'h0012, KIND_NOTE, 7'd86};
      5'd27:   b = '{16'h0027, KIND_NOTE, 7'd87};
      5'd28:   b = '{16'h0013, KIND_NOTE, 7'd88};
      5'd29:   b = '{16'h002f, KIND_NOTE, 7'd89};
      5'd30:   b = '{16'h002c, KIND_SUSTAIN, 7'd0};
      default: b = '{16'h0000, KIND_NONE, 7'd0};
    endcase
    return b;
  endfunction

endpackage

// ----- sv/hkm_ctrl.sv -----
// hkm_ctrl: sequencing state machine of the held-key note mapper
// depends on hkm_pkg; drives the command struct of hkm_dp
module hkm_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  hkm_pkg::status_t st,
  output hkm_pkg::cmd_t    cmd
);
  import hkm_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = ST_KEY;
        end
      end
      ST_KEY: begin
        // mode is the latched request mode from here on
        case (st.mode)
          MODE_KEY: begin
            if (st.out_free) begin
              cmd.key_emit = 1'b1;
              state_nxt = ST_IDLE;
            end
          end
          MODE_CANCEL: begin
            cmd.cancel = 1'b1;
            state_nxt = ST_IDLE;
          end
          MODE_REL_ALL: begin
            state_nxt = ST_SCAN;
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_SCAN: begin
        if (st.rem_zero) begin
          state_nxt = ST_IDLE;
        end else if (st.scan_held && !st.out_free) begin
          state_nxt = ST_SCAN;
        end else begin
          cmd.scan_emit = st.scan_held;
          if (st.scan_end) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.scan_next = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  a_emit_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.key_emit || cmd.scan_emit) |-> st.out_free)
    else $error("result written while output register still occupied");

  a_scan_stops_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && st.rem_zero) |=> (state_r == ST_IDLE))
    else $error("release-all scan continued past its limit");

endmodule

// ----- sv/hkm_dp.sv -----
// hkm_dp: held-key mask, held count, rom lookup, scan index and result register
// depends on hkm_pkg; steered by hkm_ctrl through the command struct
module hkm_dp #(
  parameter int KEY_COUNT = 31
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [1:0]       in_mode,
  input  logic [15:0]      in_key_usage,
  input  logic             in_is_press,
  input  logic [4:0]       in_max_releases,
  input  logic [63:0]      gesture_prefix,
  input  hkm_pkg::cmd_t    cmd,
  output hkm_pkg::status_t st,
  input  logic             out_ready,
  output logic             out_valid,
  output logic             out_accepted,
  output logic [1:0]       out_action_kind,
  output logic             out_action_pressed,
  output logic [6:0]       out_note_number,
  output logic [63:0]      out_gesture_tag,
  output logic [4:0]       out_held_count,
  output logic             out_last
);
  import hkm_pkg::*;

  localparam int N  = (KEY_COUNT < ROM_SIZE) ? KEY_COUNT : ROM_SIZE;
  localparam int IW = (N > 1) ? $clog2(N) : 1;

  // latched request
  logic [1:0]    mode_r;
  logic [15:0]   usage_r;
  logic          press_r;
  logic [4:0]    rem_r, rem_nxt;
  logic [IW-1:0] scan_idx_r, scan_idx_nxt;

  logic [N-1:0]  held_mask_r, held_mask_nxt;
  logic [4:0]    held_cnt_r, held_cnt_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic          out_acc_r, out_acc_nxt;
  logic [1:0]    out_kind_r, out_kind_nxt;
  logic          out_pressed_r, out_pressed_nxt;
  logic [6:0]    out_note_r, out_note_nxt;
  logic [63:0]   out_gid_r, out_gid_nxt;
  logic [4:0]    out_cnt_r, out_cnt_nxt;
  logic          out_last_r, out_last_nxt;

  logic          hit;
  logic [IW-1:0] key_idx;
  logic [N-1:0]  key_bit, scan_bit;
  logic          key_held, scan_held;
  binding_t      key_ent, scan_ent;
  logic          out_free;

  // parallel match of the latched usage against each of the first N rom entries
  always_comb begin
    hit     = 1'b0;
    key_idx = '0;
    for (int k = 0; k < N; k++) begin
      if (!hit && usage_r == rom_entry(ROM_IW'(k)).usage) begin
        hit     = 1'b1;
        key_idx = IW'(k);
      end
    end
  end

  assign key_bit   = N'(1) << key_idx;
  assign scan_bit  = N'(1) << scan_idx_r;
  assign key_held  = |(held_mask_r & key_bit);
  assign scan_held = |(held_mask_r & scan_bit);
  assign key_ent   = rom_entry(ROM_IW'(key_idx));
  assign scan_ent  = rom_entry(ROM_IW'(scan_idx_r));
  assign out_free  = !out_valid_r || out_ready;

  assign st.mode      = mode_r;
  assign st.rem_zero  = (rem_r == 5'd0);
  assign st.scan_held = scan_held;
  assign st.scan_end  = (scan_idx_r == IW'(N - 1));
  assign st.out_free  = out_free;

  always_comb begin
    logic key_act;
    logic key_acc;
    held_mask_nxt   = held_mask_r;
    held_cnt_nxt    = held_cnt_r;
    rem_nxt         = rem_r;
    scan_idx_nxt    = scan_idx_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_acc_nxt     = out_acc_r;
    out_kind_nxt    = out_kind_r;
    out_pressed_nxt = out_pressed_r;
    out_note_nxt    = out_note_r;
    out_gid_nxt     = out_gid_r;
    out_cnt_nxt     = out_cnt_r;
    out_last_nxt    = out_last_r;
    key_act         = 1'b0;
    key_acc         = 1'b0;

    if (cmd.load) begin
      rem_nxt      = in_max_releases;
      scan_idx_nxt = '0;
    end

    if (cmd.key_emit) begin
      if (hit) begin
        if (press_r) begin
          key_acc = 1'b1;
          if (!key_held) begin
            key_act       = 1'b1;
            held_mask_nxt = held_mask_r | key_bit;
            held_cnt_nxt  = held_cnt_r + 5'd1;
          end
        end else if (key_held) begin
          key_acc       = 1'b1;
          key_act       = 1'b1;
          held_mask_nxt = held_mask_r & ~key_bit;
          held_cnt_nxt  = held_cnt_r - 5'd1;
        end
      end
      out_valid_nxt   = 1'b1;
      out_acc_nxt     = key_acc;
      out_kind_nxt    = key_act ? key_ent.kind : KIND_NONE;
      out_pressed_nxt = key_act && press_r;
      out_note_nxt    = key_act ? key_ent.note : 7'd0;
      out_gid_nxt     = key_act ? (gesture_prefix | {48'd0, key_ent.usage}) : 64'd0;
      out_cnt_nxt     = held_cnt_nxt;
      out_last_nxt    = 1'b1;
    end

    if (cmd.cancel && hit && key_held) begin
      held_mask_nxt = held_mask_r & ~key_bit;
      held_cnt_nxt  = held_cnt_r - 5'd1;
    end

    if (cmd.scan_emit) begin
      held_mask_nxt   = held_mask_r & ~scan_bit;
      held_cnt_nxt    = held_cnt_r - 5'd1;
      rem_nxt         = rem_r - 5'd1;
      out_valid_nxt   = 1'b1;
      out_acc_nxt     = 1'b1;
      out_kind_nxt    = scan_ent.kind;
      out_pressed_nxt = 1'b0;
      out_note_nxt    = scan_ent.note;
      out_gid_nxt     = gesture_prefix | {48'd0, scan_ent.usage};
      out_cnt_nxt     = held_cnt_r - 5'd1;
      // lower bits are already cleared, so nothing left means this is the final one
      out_last_nxt    = ((held_mask_r & ~scan_bit) == '0) || (rem_r == 5'd1);
    end

    if (cmd.scan_next) begin
      scan_idx_nxt = scan_idx_r + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_mask_r <= '0;
      held_cnt_r  <= '0;
      out_valid_r <= 1'b0;
      rem_r       <= '0;
      scan_idx_r  <= '0;
    end else begin
      held_mask_r <= held_mask_nxt;
      held_cnt_r  <= held_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      rem_r       <= rem_nxt;
      scan_idx_r  <= scan_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r  <= in_mode;
      usage_r <= in_key_usage;
      press_r <= in_is_press;
    end
    out_acc_r     <= out_acc_nxt;
    out_kind_r    <= out_kind_nxt;
    out_pressed_r <= out_pressed_nxt;
    out_note_r    <= out_note_nxt;
    out_gid_r     <= out_gid_nxt;
    out_cnt_r     <= out_cnt_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_accepted       = out_acc_r;
  assign out_action_kind    = out_kind_r;
  assign out_action_pressed = out_pressed_r;
  assign out_note_number    = out_note_r;
  assign out_gesture_tag    = out_gid_r;
  assign out_held_count     = out_cnt_r;
  assign out_last           = out_last_r;

  a_count_tracks_mask: assert property (@(posedge clk) disable iff (!rst_n)
    held_cnt_r == 5'($countones(held_mask_r)))
    else $error("held count out of step with held mask");

  a_scan_result_is_release: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_emit |=> (out_valid_r && out_acc_r && !out_pressed_r))
    else $error("release-all result not an accepted release");

endmodule

// ----- sv/held_key_note_mapper.sv -----
// held_key_note_mapper: top level with the gesture prefix register and apb port
// depends on hkm_pkg, hkm_ctrl and hkm_dp
//
// a request (mode, key_usage, is_press, max_releases) is taken on in_valid and
// in_ready; results leave on out_valid and out_ready, one per cycle at most.
// a key event puts one result, marked last, in the output register from the key
// state once that register is free. cancel gives no result. release all goes on
// to the scan state, then walks KEY_COUNT rom entries (31 at most) one per
// cycle, waiting while a held key finds the output register full, and gives one
// release result per held key, up to max_releases, the final one marked last.
// the block takes one request at a time: in_ready is high while no request is
// in progress, even while a finished result still waits in the output register.
// a stalled receiver holds the result register and the scan waits at the next
// held key. gesture_prefix is a 64-bit register at byte address 0 of the apb
// port; the user must write it only while idle, which the block itself does not
// enforce. reset clears the held mask, the held count, the gesture prefix and
// the output valid; the block is ready the cycle after reset.
module held_key_note_mapper #(
  parameter int KEY_COUNT = 31
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [15:0] in_key_usage,
  input  logic        in_is_press,
  input  logic [4:0]  in_max_releases,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_accepted,
  output logic [1:0]  out_action_kind,
  output logic        out_action_pressed,
  output logic [6:0]  out_note_number,
  output logic [63:0] out_gesture_tag,
  output logic [4:0]  out_held_count,
  output logic        out_last,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);
  import hkm_pkg::*;

  logic [63:0] prefix_r;
  cmd_t        cmd;
  status_t     st;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefix_r <= '0;
    end else if (cfg_wr && cfg_paddr[3] == REG_GESTURE_PREFIX) begin
      prefix_r <= cfg_pwdata;
    end
  end

  assign cfg_prdata = (cfg_paddr[3] == REG_GESTURE_PREFIX) ? prefix_r : 64'd0;

  hkm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  hkm_dp #(
    .KEY_COUNT (KEY_COUNT)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_mode            (in_mode),
    .in_key_usage       (in_key_usage),
    .in_is_press        (in_is_press),
    .in_max_releases    (in_max_releases),
    .gesture_prefix     (prefix_r),
    .cmd                (cmd),
    .st                 (st),
    .out_ready          (out_ready),
    .out_valid          (out_valid),
    .out_accepted       (out_accepted),
    .out_action_kind    (out_action_kind),
    .out_action_pressed (out_action_pressed),
    .out_note_number    (out_note_number),
    .out_gesture_tag    (out_gesture_tag),
    .out_held_count     (out_held_count),
    .out_last           (out_last)
  );

endmodule

// ----- tb/tb.sv -----
// tb: self-checking testbench for held_key_note_mapper, with its scoreboard class
// depends on hkm_pkg and held_key_note_mapper; drives requests, apb writes and
// result stalls, and predicts every result from its own copy of the held-key mask
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hkm_pkg::*;

  localparam int KEYS = 31;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [15:0] SUSTAIN_USAGE = 16'h002c;
  localparam logic [6:0] LOWEST_NOTE = 7'd60;
  localparam logic [3:0] PREFIX_ADDR = 4'(8 * REG_GESTURE_PREFIX);
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_ITEMS = 40;

  // binding table, index 0 first
  localparam logic [0:KEYS-1][15:0] KEY_USAGE = {
    16'h001d, 16'h0016, 16'h001b, 16'h0007, 16'h0006, 16'h0019, 16'h000a, 16'h0005,
    16'h000b, 16'h0011, 16'h000d, 16'h0010, 16'h0014, 16'h001f, 16'h001a, 16'h0020,
    16'h0008, 16'h0015, 16'h0022, 16'h0017, 16'h0023, 16'h001c, 16'h0024, 16'h0018,
    16'h000c, 16'h0026, 16'h0012, 16'h0027, 16'h0013, 16'h002f, 16'h002c
  };

  typedef struct packed {
    logic        accepted;
    logic [1:0]  kind;
    logic        pressed;
    logic [6:0]  note;
    logic [63:0] gesture;
    logic [4:0]  held;
    logic        last;
  } note_result_t;

  class note_scoreboard;
    logic [KEYS-1:0] held;
    logic [63:0] prefix;
    note_result_t pending[$];
    int errors;
    int requests;
    int checked;

    function new();
      held = '0;
      prefix = '0;
      errors = 0;
      requests = 0;
      checked = 0;
    endfunction

    function int find_key(logic [15:0] usage);
      int i;
      for (i = 0; i < KEYS; i++) begin
        if (KEY_USAGE[i] == usage) return i;
      end
      return KEYS;
    endfunction

    // held count is taken after the mask update
    function note_result_t make_result(logic acc, int idx, bit act, logic pressed);
      note_result_t r;
      r = '0;
      r.accepted = acc;
      r.held = 5'($countones(held));
      r.last = 1'b1;
      if (act) begin
        r.pressed = pressed;
        r.gesture = prefix | {48'd0, KEY_USAGE[idx]};
        if (KEY_USAGE[idx] == SUSTAIN_USAGE) begin
          r.kind = KIND_SUSTAIN;
        end else begin
          r.kind = KIND_NOTE;
          r.note = LOWEST_NOTE + 7'(idx);
        end
      end
      return r;
    endfunction

    function void note_request(logic [1:0] mode, logic [15:0] usage, logic press,
                               logic [4:0] limit);
      int idx;
      int emitted;
      note_result_t r;
      requests++;
      idx = find_key(usage);
      case (mode)
        MODE_KEY: begin
          if (idx == KEYS) begin
            pending.push_back(make_result(1'b0, 0, 0, 1'b0));
          end else if (press && held[idx]) begin
            pending.push_back(make_result(1'b1, idx, 0, 1'b0));
          end else if (!press && !held[idx]) begin
            pending.push_back(make_result(1'b0, idx, 0, 1'b0));
          end else begin
            held[idx] = press;
            pending.push_back(make_result(1'b1, idx, 1, press));
          end
        end
        MODE_CANCEL: begin
          if (idx < KEYS) held[idx] = 1'b0;
        end
        MODE_REL_ALL: begin
          emitted = 0;
          for (int i = 0; i < KEYS && emitted < int'(limit); i++) begin
            if (held[i]) begin
              held[i] = 1'b0;
              r = make_result(1'b1, i, 1, 1'b0);
              r.last = 1'b0;
              pending.push_back(r);
              emitted++;
            end
          end
          if (emitted > 0) pending[pending.size() - 1].last = 1'b1;
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(note_result_t got);
      note_result_t want;
      if (pending.size() == 0) begin
        $error("result with nothing expected: 0x%0h", got);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      compare_field("accepted", 64'(want.accepted), 64'(got.accepted));
      compare_field("action_kind", 64'(want.kind), 64'(got.kind));
      compare_field("action_pressed", 64'(want.pressed), 64'(got.pressed));
      compare_field("note_number", 64'(want.note), 64'(got.note));
      compare_field("gesture_tag", want.gesture, got.gesture);
      compare_field("held_count", 64'(want.held), 64'(got.held));
      compare_field("last", 64'(want.last), 64'(got.last));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_mode = MODE_KEY;
  logic [15:0] in_key_usage = '0;
  logic        in_is_press = 1'b0;
  logic [4:0]  in_max_releases = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_accepted;
  logic [1:0]  out_action_kind;
  logic        out_action_pressed;
  logic [6:0]  out_note_number;
  logic [63:0] out_gesture_tag;
  logic [4:0]  out_held_count;
  logic        out_last;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [63:0] cfg_pwdata = '0;
  logic [63:0] cfg_prdata;
  logic        cfg_pready;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int prefix_writes = 0;
  note_scoreboard sb;

  held_key_note_mapper dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // results are checked before the request taken on the same edge is noted
  always @(posedge clk) begin
    note_result_t seen;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        seen = '{out_accepted, out_action_kind, out_action_pressed, out_note_number,
                 out_gesture_tag, out_held_count, out_last};
        sb.check_result(seen);
      end
      if (in_valid && in_ready)
        sb.note_request(in_mode, in_key_usage, in_is_press, in_max_releases);
    end
  end

  // called and returns at a falling edge; valid is left high after acceptance
  task automatic send_request(input logic [1:0] mode, input logic [15:0] usage,
                              input logic press, input logic [4:0] limit);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_key_usage <= usage;
    in_is_press <= press;
    in_max_releases <= limit;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // drain, then allow for a scan that gives no result before touching the register
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_prefix(input logic [63:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= PREFIX_ADDR;
    cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    sb.prefix = value;
    prefix_writes++;
    @(negedge clk);
    cfg_pwrite <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata !== value) begin
      $error("gesture_prefix readback: expected 0x%0h, got 0x%0h", value, cfg_prdata);
      sb.errors++;
    end
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  function automatic logic [15:0] held_or_any_key();
    int start;
    int k;
    start = $urandom_range(KEYS - 1);
    for (k = 0; k < KEYS; k++) begin
      if (sb.held[(start + k) % KEYS]) return KEY_USAGE[(start + k) % KEYS];
    end
    return KEY_USAGE[start];
  endfunction

  // mostly well-formed presses and releases, with cancels, release-all and noise
  task automatic send_random_request();
    int roll;
    logic [1:0] mode;
    logic [15:0] usage;
    logic press;
    logic [4:0] limit;
    roll = $urandom_range(99);
    mode = MODE_KEY;
    usage = KEY_USAGE[$urandom_range(KEYS - 1)];
    press = 1'($urandom_range(1));
    limit = 5'($urandom_range(31));
    if (roll < 45) begin
      press = 1'b1;
    end else if (roll < 70) begin
      usage = held_or_any_key();
      press = 1'b0;
    end else if (roll < 78) begin
      mode = MODE_CANCEL;
      if (roll == 77) usage = 16'($urandom);
    end else if (roll < 88) begin
      mode = MODE_REL_ALL;
      if (roll < 84) limit = 5'($urandom_range(1, 4));
    end else begin
      usage = 16'($urandom);
    end
    send_request(mode, usage, press, limit);
  endtask

  task automatic run_random(input int count);
    repeat (count) send_random_request();
    settle();
  endtask

  initial begin
    sb = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    write_prefix(64'd0);
    send_request(MODE_REL_ALL, 16'h0000, 1'b0, 5'd31);     // nothing held
    send_request(MODE_KEY, KEY_USAGE[0], 1'b0, 5'd0);      // stray release
    send_request(MODE_KEY, 16'h0000, 1'b1, 5'd0);
    send_request(MODE_KEY, 16'hffff, 1'b0, 5'd31);
    send_request(MODE_KEY, 16'h101d, 1'b1, 5'd7);          // bound low byte, unbound usage
    send_request(MODE_KEY, KEY_USAGE[0], 1'b1, 5'd0);
    send_request(MODE_KEY, KEY_USAGE[0], 1'b1, 5'd31);     // repeat press
    send_request(MODE_KEY, KEY_USAGE[30], 1'b1, 5'd0);     // sustain pedal
    send_request(MODE_KEY, KEY_USAGE[29], 1'b1, 5'd0);
    send_request(MODE_KEY, KEY_USAGE[29], 1'b0, 5'd0);
    send_request(MODE_CANCEL, KEY_USAGE[0], 1'b1, 5'd31);
    send_request(MODE_CANCEL, 16'hffff, 1'b0, 5'd0);
    send_request(MODE_KEY, KEY_USAGE[0], 1'b0, 5'd0);      // cancelled, so stray now
    send_request(MODE_UNUSED, KEY_USAGE[30], 1'b1, 5'd31);
    send_request(MODE_KEY, KEY_USAGE[1], 1'b1, 5'd0);
    send_request(MODE_KEY, KEY_USAGE[2], 1'b1, 5'd0);
    send_request(MODE_KEY, KEY_USAGE[3], 1'b1, 5'd0);
    send_request(MODE_REL_ALL, 16'hffff, 1'b1, 5'd0);      // zero limit
    send_request(MODE_REL_ALL, 16'h0000, 1'b0, 5'd2);      // limit leaves keys held
    send_request(MODE_REL_ALL, 16'h0000, 1'b0, 5'd31);
    send_request(MODE_KEY, KEY_USAGE[30], 1'b0, 5'd0);
    send_request(MODE_KEY, KEY_USAGE[30], 1'b1, 5'd0);
    send_request(MODE_KEY, KEY_USAGE[30], 1'b0, 5'd0);
    settle();

    write_prefix({64{1'b1}});
    run_random(PHASE_ITEMS);

    write_prefix({$urandom, $urandom});
    send_idle_pct = 73;
    run_random(PHASE_ITEMS);

    write_prefix(64'haaaa_5555_aaaa_5555);
    send_idle_pct = 0;
    stall_pct = 73;
    run_random(PHASE_ITEMS);

    write_prefix({$urandom, $urandom});
    send_idle_pct = 37;
    stall_pct = 37;
    // every key held, then one full burst into a stalling receiver
    for (int i = 0; i < KEYS; i++) send_request(MODE_KEY, KEY_USAGE[i], 1'b1, 5'($urandom));
    send_request(MODE_REL_ALL, 16'($urandom), 1'($urandom), 5'd31);
    run_random(PHASE_ITEMS);

    $display("%0d requests, %0d results checked, %0d gesture prefix settings",
             sb.requests, sb.checked, prefix_writes);
    $display("idling phases: none, sender 73%%, receiver 73%%, both 37%%");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  initial begin
    #6_000_000;
    $display("timeout with %0d results outstanding", sb.pending.size());
    $display("tb failed");
    $finish;
  end

endmodule
